// ===== design/mcr_pkg.sv =====
package mcr_pkg;

    localparam logic OP_WRITE    = 1'b1;
    localparam int   ARITH_BYTES = 48;
    localparam int   UMUL_BASE   = 0;
    localparam int   SMUL_BASE   = 8;
    localparam int   UDIV_BASE   = 16;
    localparam int   SDIV_BASE   = 24;
    localparam int   ADD_BASE    = 32;
    localparam int   DIV_STEPS   = 16;

    typedef enum logic [2:0] {
        GRP_NONE,
        GRP_UMUL,
        GRP_SMUL,
        GRP_UDIV,
        GRP_SDIV,
        GRP_ADD
    } grp_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic mul;
        logic add;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        grp_t grp;
        logic div_last;
    } stat_t;

endpackage

// ===== design/mcr_datapath.sv =====
module mcr_datapath #(
    parameter int REG_COUNT = 160
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mcr_pkg::cmd_t cmd,
    output mcr_pkg::stat_t stat,
    input  logic          opcode,
    input  logic [7:0]    reg_offset,
    input  logic [1:0]    access_size,
    input  logic [7:0]    write_data,
    output logic [15:0]   read_data
);
    import mcr_pkg::*;

    localparam int MEM_DEPTH = (REG_COUNT > ARITH_BYTES) ? REG_COUNT - ARITH_BYTES : 1;
    localparam int MW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // request registers
    logic       op_reg;
    logic [7:0] off_reg;
    logic [1:0] size_reg;
    logic [7:0] wd_reg;

    // offsets 0..47, little-endian bytes
    logic [ARITH_BYTES*8-1:0] low_reg;

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] mem_valid_reg;
    logic [7:0]           rd0_reg;
    logic [7:0]           rd1_reg;

    logic [15:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [3:0]  cnt_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        zero_reg;

    logic [15:0] read_data_reg;

    logic [8:0]    off_hi;
    logic          in_range0;
    logic          in_range1;
    logic          is_low0;
    logic          is_low1;
    logic [MW-1:0] addr0;
    logic [MW-1:0] addr1;
    logic [5:0]    lo6;
    logic [5:0]    hi6;
    grp_t          grp;
    logic          is_write;

    logic        mul_signed;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [33:0] mul_p;

    logic        div_signed;
    logic [15:0] div_a;
    logic [15:0] div_b;
    logic        sa;
    logic        sb;

    logic [16:0] shifted;
    logic [16:0] trial;
    logic        qbit;
    logic [15:0] rem_step;
    logic [15:0] q_fin;
    logic [15:0] q_out;
    logic [15:0] r_out;

    logic [7:0]  byte0;
    logic [7:0]  byte1;

    assign is_write  = (op_reg == OP_WRITE);
    assign off_hi    = {1'b0, off_reg} + 9'd1;
    assign in_range0 = ({1'b0, off_reg} < 9'(REG_COUNT));
    assign in_range1 = (off_hi < 9'(REG_COUNT));
    assign is_low0   = (off_reg < 8'(ARITH_BYTES));
    assign is_low1   = (off_hi < 9'(ARITH_BYTES));
    assign addr0     = MW'(off_reg - 8'(ARITH_BYTES));
    assign addr1     = MW'(off_hi - 9'(ARITH_BYTES));
    assign lo6       = off_reg[5:0];
    assign hi6       = off_hi[5:0];

    always_comb
    begin
        grp = GRP_NONE;
        if (is_low0)
        begin
            case (off_reg[5:3])
                3'd0:    grp = GRP_UMUL;
                3'd1:    grp = GRP_SMUL;
                3'd2:    grp = GRP_UDIV;
                3'd3:    grp = GRP_SDIV;
                3'd4:    grp = GRP_ADD;
                3'd5:    grp = GRP_ADD;
                default: grp = GRP_NONE;
            endcase
        end
    end

    assign stat.is_write = is_write;
    assign stat.grp      = grp;
    assign stat.div_last = (cnt_reg == 4'(DIV_STEPS - 1));

    // multiplier: 17x17 signed covers both modes
    assign mul_signed = (grp == GRP_SMUL);
    assign mul_a = mul_signed ? low_reg[SMUL_BASE*8 +: 16] : low_reg[UMUL_BASE*8 +: 16];
    assign mul_b = mul_signed ? low_reg[SMUL_BASE*8+16 +: 16] : low_reg[UMUL_BASE*8+16 +: 16];
    assign mul_p = $signed({mul_signed & mul_a[15], mul_a})
                 * $signed({mul_signed & mul_b[15], mul_b});

    // divider operands, magnitudes for the signed group
    assign div_signed = (grp == GRP_SDIV);
    assign div_a = div_signed ? low_reg[SDIV_BASE*8 +: 16] : low_reg[UDIV_BASE*8 +: 16];
    assign div_b = div_signed ? low_reg[SDIV_BASE*8+16 +: 16] : low_reg[UDIV_BASE*8+16 +: 16];
    assign sa    = div_signed & div_a[15];
    assign sb    = div_signed & div_b[15];

    // restoring division, one quotient bit per step
    assign shifted  = {rem_reg, dvd_reg[15]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign qbit     = ~trial[16];
    assign rem_step = qbit ? trial[15:0] : shifted[15:0];
    assign q_fin    = {dvd_reg[14:0], qbit};
    assign q_out    = zero_reg ? 16'd0 : (neg_q_reg ? 16'(-q_fin) : q_fin);
    assign r_out    = zero_reg ? 16'd0 : (neg_r_reg ? 16'(-rem_step) : rem_step);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            off_reg  <= reg_offset;
            size_reg <= access_size;
            wd_reg   <= write_data;
        end
        if (cmd.div_start)
        begin
            dvd_reg   <= sa ? 16'(-div_a) : div_a;
            dvs_reg   <= sb ? 16'(-div_b) : div_b;
            rem_reg   <= '0;
            neg_q_reg <= sa ^ sb;
            neg_r_reg <= sa;
            zero_reg  <= (div_b == 16'd0);
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= q_fin;
            rem_reg <= rem_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= 1'b0;
            cnt_reg <= '0;
            low_reg <= '0;
        end
        else
        begin
            if (cmd.latch)
                op_reg <= opcode;
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 4'd1;
            if (cmd.exec && is_write && is_low0)
                low_reg[{lo6, 3'b000} +: 8] <= wd_reg;
            if (cmd.mul)
            begin
                if (mul_signed)
                    low_reg[SMUL_BASE*8+32 +: 32] <= mul_p[31:0];
                else
                    low_reg[UMUL_BASE*8+32 +: 32] <= mul_p[31:0];
            end
            if (cmd.add)
                low_reg[ADD_BASE*8+64 +: 32] <= low_reg[ADD_BASE*8 +: 32]
                                              + low_reg[ADD_BASE*8+32 +: 32];
            if (cmd.div_step && stat.div_last)
            begin
                if (div_signed)
                    low_reg[SDIV_BASE*8+32 +: 32] <= {r_out, q_out};
                else
                    low_reg[UDIV_BASE*8+32 +: 32] <= {r_out, q_out};
            end
        end
    end

    // plain storage above the arithmetic groups
    always_ff @(posedge clk)
    begin
        if (cmd.exec && is_write && in_range0 && !is_low0)
            mem[addr0] <= wd_reg;
        rd0_reg <= mem_valid_reg[addr0] ? mem[addr0] : 8'd0;
        rd1_reg <= mem_valid_reg[addr1] ? mem[addr1] : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mem_valid_reg <= '0;
        else if (cmd.exec && is_write && in_range0 && !is_low0)
            mem_valid_reg[addr0] <= 1'b1;
    end

    always_comb
    begin
        byte0 = 8'd0;
        byte1 = 8'd0;
        if (!is_write && in_range0)
        begin
            byte0 = is_low0 ? low_reg[{lo6, 3'b000} +: 8] : rd0_reg;
            if (size_reg == 2'd2 && in_range1)
                byte1 = is_low1 ? low_reg[{hi6, 3'b000} +: 8] : rd1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            read_data_reg <= {byte1, byte0};
    end

    assign read_data = read_data_reg;

    property p_div_init;
        @(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (cnt_reg == 4'd0);
    endproperty
    a_div_init: assert property (p_div_init) else $error("divider count not cleared");

    property p_write_reads_zero;
        @(posedge clk) disable iff (!rst_n)
        (cmd.load_out && is_write) |=> (read_data == 16'd0);
    endproperty
    a_write_reads_zero: assert property (p_write_reads_zero)
        else $error("write request returned nonzero data");

    property p_sum_holds;
        @(posedge clk) disable iff (!rst_n)
        cmd.add |=> (low_reg[ADD_BASE*8+64 +: 32] ==
                     low_reg[ADD_BASE*8 +: 32] + low_reg[ADD_BASE*8+32 +: 32]);
    endproperty
    a_sum_holds: assert property (p_sum_holds) else $error("adder result mismatch");

endmodule

// ===== design/mcr_ctrl.sv =====
module mcr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output mcr_pkg::cmd_t  cmd,
    input  mcr_pkg::stat_t stat
);
    import mcr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ADD,
        S_DIV_INIT,
        S_DIV,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch = accept;
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!stat.is_write)
                    state_next = S_RESULT;
                else
                begin
                    case (stat.grp)
                        GRP_UMUL: state_next = S_MUL;
                        GRP_SMUL: state_next = S_MUL;
                        GRP_UDIV: state_next = S_DIV_INIT;
                        GRP_SDIV: state_next = S_DIV_INIT;
                        GRP_ADD:  state_next = S_ADD;
                        default:  state_next = S_RESULT;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RESULT;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_RESULT;
            end
            S_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.load_out = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    property p_accept_exec;
        @(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC);
    endproperty
    a_accept_exec: assert property (p_accept_exec) else $error("accepted request not executed");

    property p_div_end;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_last) |=> (state_reg == S_RESULT);
    endproperty
    a_div_end: assert property (p_div_end) else $error("divide did not finish");

    property p_load_sets_valid;
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (out_valid_reg && state_reg == S_IDLE);
    endproperty
    a_load_sets_valid: assert property (p_load_sets_valid) else $error("result lost");

endmodule

// ===== design/math_coprocessor_registers.sv =====
// Byte-addressed coprocessor register file with multiply, divide and add groups.
// Request channel: in_valid/in_stall with opcode, reg_offset, access_size,
// write_data. A request is taken when in_valid is high and in_stall is low.
// Response channel: out_valid/out_stall with read_data; every request gives
// exactly one response (zero for writes, zero high byte for 1-byte reads).
// One request is processed at a time; in_stall is low only while idle.
// States from accept to response valid:
//   read, or write outside the arithmetic groups: execute, result
//   write to a multiply or adder group: execute, multiply or add, result
//   write to a divide group: execute, divider init, 16 restoring divider steps, result
// The divider loop sets the slowest case; the rest is one register stage per
// command. The next request is taken the cycle after the response loads.
// The response sits in an output register, so the next request is
// taken while it waits; a stalled receiver holds the block in its final state
// until the register frees up.
// Reset clears all bytes to zero at once (valid bits on plain storage).
module math_coprocessor_registers #(
    parameter int REG_COUNT = 160
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  reg_offset,
    input  logic [1:0]  access_size,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data
);
    import mcr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mcr_datapath #(
        .REG_COUNT (REG_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .reg_offset  (reg_offset),
        .access_size (access_size),
        .write_data  (write_data),
        .read_data   (read_data)
    );

endmodule

// ===== tb/tb_math_coprocessor_registers.sv =====
module tb_math_coprocessor_registers;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    localparam int   REG_COUNT  = 160;
    localparam logic OP_READ    = 1'b0;
    localparam logic [1:0] SIZE_ONE = 2'd1;
    localparam logic [1:0] SIZE_TWO = 2'd2;
    localparam int   IDLE_LIMIT = 5000;
    localparam int   DRAIN_WAIT = 25;
    localparam int   HOLD_OFF   = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  reg_offset;
    logic [1:0]  access_size;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] read_data;

    logic [7:0]  model_bytes [REG_COUNT];
    logic [15:0] expected_reads [$];
    int          error_count;
    int          idle_cycles;
    int          hold_request;
    bit          no_idle;

    math_coprocessor_registers #(
        .REG_COUNT(REG_COUNT)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .reg_offset (reg_offset),
        .access_size(access_size),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] get16(int base);
        return {model_bytes[base + 1], model_bytes[base]};
    endfunction

    function automatic void put16(int base, logic [15:0] v);
        model_bytes[base]     = v[7:0];
        model_bytes[base + 1] = v[15:8];
    endfunction

    function automatic void put32(int base, logic [31:0] v);
        put16(base, v[15:0]);
        put16(base + 2, v[31:16]);
    endfunction

    function automatic void recompute_group(int off);
        int a;
        int b;
        logic [15:0] ub;
        logic [15:0] q;
        logic [15:0] r;
        logic [31:0] sum;
        case (off >> 3)
            UMUL_BASE >> 3:
            begin
                a = int'(get16(UMUL_BASE));
                b = int'(get16(UMUL_BASE + 2));
                put32(UMUL_BASE + 4, 32'(a) * 32'(b));
            end
            SMUL_BASE >> 3:
            begin
                a = int'($signed(get16(SMUL_BASE)));
                b = int'($signed(get16(SMUL_BASE + 2)));
                put32(SMUL_BASE + 4, 32'(a * b));
            end
            UDIV_BASE >> 3:
            begin
                a  = int'(get16(UDIV_BASE));
                b  = int'(get16(UDIV_BASE + 2));
                q  = (b != 0) ? 16'(a / b) : 16'h0;
                r  = (b != 0) ? 16'(a % b) : 16'h0;
                put16(UDIV_BASE + 4, q);
                put16(UDIV_BASE + 6, r);
            end
            SDIV_BASE >> 3:
            begin
                ub = get16(SDIV_BASE + 2);
                a  = int'($signed(get16(SDIV_BASE)));
                b  = int'($signed(ub));
                q  = (ub != 0) ? 16'(a / b) : 16'h0;
                r  = (ub != 0) ? 16'(a % b) : 16'h0;
                put16(SDIV_BASE + 4, q);
                put16(SDIV_BASE + 6, r);
            end
            ADD_BASE >> 3, (ADD_BASE >> 3) + 1:
            begin
                sum = {get16(ADD_BASE + 2), get16(ADD_BASE)}
                    + {get16(ADD_BASE + 6), get16(ADD_BASE + 4)};
                put32(ADD_BASE + 8, sum);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] predict_access(logic op, int off, logic [1:0] size,
                                                    logic [7:0] wd);
        logic [15:0] rd;
        rd = 16'h0;
        if (off < REG_COUNT) begin
            if (op == OP_WRITE) begin
                model_bytes[off] = wd;
                recompute_group(off);
            end
            else
            begin
                rd[7:0] = model_bytes[off];
                if (size == SIZE_TWO && off + 1 < REG_COUNT)
                    rd[15:8] = model_bytes[off + 1];
            end
        end
        return rd;
    endfunction

    task automatic send_request(logic op, logic [7:0] off, logic [1:0] size, logic [7:0] wd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        reg_offset  <= off;
        access_size <= size;
        write_data  <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_reads.push_back(predict_access(op, off, size, wd));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // operand writes into one group, then reads back the whole group
    task automatic run_group_sequence();
        int base;
        int n_ops;
        base  = 8 * $urandom_range(0, 5);
        n_ops = (base >= ADD_BASE) ? 8 : 4;
        if (base == 8 * 5)
            base = ADD_BASE;
        for (int i = 0; i < n_ops; i++)
            if ($urandom_range(0, 3) != 0)
                send_request(OP_WRITE, 8'(base + i), 2'($urandom), edge_byte());
        for (int i = 0; i < ((base >= ADD_BASE) ? 16 : 8); i += 2)
            send_request(OP_READ, 8'(base + i), SIZE_TWO, 8'($urandom));
    endtask

    task automatic test_directed();
        send_request(OP_WRITE, 8'(UMUL_BASE),     SIZE_ONE, 8'hFF);
        send_request(OP_WRITE, 8'(UMUL_BASE + 1), SIZE_TWO, 8'hFF);
        send_request(OP_WRITE, 8'(UMUL_BASE + 2), SIZE_ONE, 8'hFF);
        send_request(OP_WRITE, 8'(UMUL_BASE + 3), SIZE_ONE, 8'hFF);
        send_request(OP_READ,  8'(UMUL_BASE + 4), SIZE_TWO, 8'h00);
        send_request(OP_READ,  8'(UMUL_BASE + 6), SIZE_TWO, 8'h00);
        send_request(OP_WRITE, 8'(SMUL_BASE + 1), SIZE_ONE, 8'h80);
        send_request(OP_WRITE, 8'(SMUL_BASE + 3), SIZE_ONE, 8'h80);
        send_request(OP_READ,  8'(SMUL_BASE + 6), SIZE_TWO, 8'h00);
        // divide by zero
        send_request(OP_WRITE, 8'(UDIV_BASE),     SIZE_ONE, 8'h37);
        send_request(OP_READ,  8'(UDIV_BASE + 4), SIZE_TWO, 8'h00);
        // most negative over minus one
        send_request(OP_WRITE, 8'(SDIV_BASE + 1), SIZE_ONE, 8'h80);
        send_request(OP_WRITE, 8'(SDIV_BASE + 2), SIZE_ONE, 8'hFF);
        send_request(OP_WRITE, 8'(SDIV_BASE + 3), SIZE_ONE, 8'hFF);
        send_request(OP_READ,  8'(SDIV_BASE + 4), SIZE_TWO, 8'h00);
        send_request(OP_READ,  8'(SDIV_BASE + 6), SIZE_TWO, 8'h00);
        send_request(OP_WRITE, 8'(ADD_BASE + 3),  SIZE_ONE, 8'hFF);
        send_request(OP_WRITE, 8'(ADD_BASE + 7),  SIZE_ONE, 8'hFF);
        send_request(OP_READ,  8'(ADD_BASE + 10), SIZE_TWO, 8'h00);
        // result byte overwritten by recompute
        send_request(OP_WRITE, 8'(ADD_BASE + 9),  SIZE_ONE, 8'h5A);
        send_request(OP_READ,  8'(ADD_BASE + 8),  SIZE_TWO, 8'h00);
        send_request(OP_WRITE, 8'd159, SIZE_ONE, 8'hA5);
        send_request(OP_READ,  8'd159, SIZE_TWO, 8'h00);
        send_request(OP_WRITE, 8'd255, SIZE_ONE, 8'h11);
        send_request(OP_READ,  8'd200, 2'd3, 8'h00);
    endtask

    task automatic test_group_sequences();
        for (int i = 0; i < 110; i++)
            run_group_sequence();
    endtask

    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_request = HOLD_OFF;
        for (int i = 0; i < 20; i++)
            send_request(OP_READ, 8'($urandom_range(0, 47)), SIZE_TWO, 8'h00);
        no_idle = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 640; i++)
            send_request(1'($urandom), ($urandom_range(0, 9) == 0) ? 8'($urandom)
                         : 8'($urandom_range(0, REG_COUNT - 1)), 2'($urandom), 8'($urandom));
    endtask

    task automatic test_no_gaps();
        no_idle = 1'b1;
        for (int i = 0; i < 20; i++)
            run_group_sequence();
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall) begin
            if (expected_reads.size() == 0) begin
                $error("read_data: unexpected response %h", read_data);
                error_count++;
            end
            else
            begin
                if (read_data !== expected_reads[0]) begin
                    $error("read_data: expected %h, actual %h", expected_reads[0], read_data);
                    error_count++;
                end
                void'(expected_reads.pop_front());
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0) begin
                out_stall <= 1'b1;
                hold_request--;
            end
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_math_coprocessor_registers: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        error_count  = 0;
        hold_request = 0;
        no_idle      = 1'b0;
        for (int i = 0; i < REG_COUNT; i++)
            model_bytes[i] = 8'h00;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_READ;
        reg_offset  <= 8'h00;
        access_size <= SIZE_ONE;
        write_data  <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_group_sequences();
        test_backpressure();
        test_random_mix();
        test_no_gaps();
        wait_drain();

        if (error_count == 0 && expected_reads.size() == 0)
            $display("tb_math_coprocessor_registers: PASS");
        else
            $display("tb_math_coprocessor_registers: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/mcr_pkg.sv
design/mcr_datapath.sv
design/mcr_ctrl.sv
design/math_coprocessor_registers.sv
tb/tb_math_coprocessor_registers.sv
